### rtl/core/sfad_pkg.sv
// Shared types, constants and helper functions for the stereo atan distortion core.
// No dependencies; used by sfad_mul, sfad_cordic and stereo_filtered_atan_distortion.
`timescale 1ns / 1ps
`default_nettype none

package sfad_pkg;

  // config port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_LOW_CUT_GAIN      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_CUT_FEEDBACK  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_CUT_GAIN     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_CUT_FEEDBACK = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_SCALE       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_SCALE      = 3'd5;

  localparam int GAIN_W  = 23;
  localparam int FB_W    = 24;
  localparam int DRIVE_W = 32;
  localparam int OSCL_W  = 16;

  localparam logic [GAIN_W-1:0]         LOW_CUT_GAIN_RST      = 23'd4120900;
  localparam logic signed [FB_W-1:0]    LOW_CUT_FEEDBACK_RST  = -24'sd4047505;
  localparam logic [GAIN_W-1:0]         HIGH_CUT_GAIN_RST     = 23'd3220400;
  localparam logic signed [FB_W-1:0]    HIGH_CUT_FEEDBACK_RST = 24'sd2246600;
  localparam logic [DRIVE_W-1:0]        DRIVE_SCALE_RST       = 32'd82355;
  localparam logic [OSCL_W-1:0]         OUTPUT_SCALE_RST      = 16'd20840;

  // datapath widths
  localparam int MUL_W  = 33;           // multiplier operand, signed
  localparam int PROD_W = 2 * MUL_W;    // registered product
  localparam int ACC_W  = 48;           // filter sums before saturation
  localparam int MEM_W  = 32;           // filter state and outputs
  localparam int V_W    = 34;           // feedforward terms
  localparam int T_W    = 48;           // pre-gained magnitude
  localparam int T_SHIFT = 16;
  localparam logic [PROD_W-1:0] T_HALF = 66'd32768;

  // cordic
  localparam int ROM_SIZE = 32;
  localparam int ITER_W   = 5;
  localparam int ANG_W    = 30;
  localparam int X_W      = 34;
  localparam int Y_W      = T_W + 1;
  localparam int Z_W      = 33;
  localparam int ZC_W     = 32;
  localparam int NORM_BIT = 30;

  typedef struct packed {
    logic busy;
    logic done;
  } cor_stat_t;

  // angles of atan(2^-i), units of 2^-30 rad
  function automatic logic [ANG_W-1:0] atan_angle(input logic [ITER_W-1:0] idx);
    logic [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 30'h3243F6A8;
      5'd1:    a = 30'h1DAC6705;
      5'd2:    a = 30'h0FADBAFC;
      5'd3:    a = 30'h07F56EA6;
      5'd4:    a = 30'h03FEAB76;
      5'd5:    a = 30'h01FFD55B;
      5'd6:    a = 30'h00FFFAAA;
      5'd7:    a = 30'h007FFF55;
      5'd8:    a = 30'h003FFFEA;
      5'd9:    a = 30'h001FFFFD;
      5'd10:   a = 30'h000FFFFF;
      5'd11:   a = 30'h0007FFFF;
      5'd12:   a = 30'h0003FFFF;
      5'd13:   a = 30'h0001FFFF;
      5'd14:   a = 30'h0000FFFF;
      5'd15:   a = 30'h00007FFF;
      5'd16:   a = 30'h00003FFF;
      5'd17:   a = 30'h00001FFF;
      5'd18:   a = 30'h00000FFF;
      5'd19:   a = 30'h000007FF;
      5'd20:   a = 30'h000003FF;
      5'd21:   a = 30'h000001FF;
      5'd22:   a = 30'h000000FF;
      5'd23:   a = 30'h0000007F;
      5'd24:   a = 30'h0000003F;
      5'd25:   a = 30'h0000001F;
      5'd26:   a = 30'h0000000F;
      5'd27:   a = 30'h00000008;
      5'd28:   a = 30'h00000004;
      5'd29:   a = 30'h00000002;
      5'd30:   a = 30'h00000001;
      default: a = 30'h00000000;
    endcase
    return a;
  endfunction

  // floor((p + 2^21) / 2^22)
  function automatic logic signed [ACC_W-1:0] rnd22(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] q;
    s = p + 66'sd2097152;
    q = s >>> 22;
    return q[ACC_W-1:0];
  endfunction

  function automatic logic signed [MEM_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [MEM_W-1:0] r;
    hi = {{(ACC_W-MEM_W+1){1'b0}}, {(MEM_W-1){1'b1}}};
    lo = {{(ACC_W-MEM_W+1){1'b1}}, {(MEM_W-1){1'b0}}};
    if (a > hi) begin
      r = hi[MEM_W-1:0];
    end else if (a < lo) begin
      r = lo[MEM_W-1:0];
    end else begin
      r = a[MEM_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sfad_mul.sv
// Shared signed multiplier with a registered product.
// Depends on sfad_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module sfad_mul (
  input  wire                                   clk_i,
  input  wire  logic signed [sfad_pkg::MUL_W-1:0]  a_i,
  input  wire  logic signed [sfad_pkg::MUL_W-1:0]  b_i,
  output logic signed [sfad_pkg::PROD_W-1:0]      p_o
);

  logic signed [sfad_pkg::PROD_W-1:0] p_q;
  logic signed [sfad_pkg::PROD_W-1:0] p_d;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/core/sfad_cordic.sv
// Vectoring CORDIC arctangent: operand normalization then one rotation per cycle.
// Depends on sfad_pkg (angle table, widths, status struct).
`timescale 1ns / 1ps
`default_nettype none

module sfad_cordic #(
  parameter int FRAC_BITS = 23,
  parameter int NITER     = 20
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  wire  logic [sfad_pkg::T_W-1:0]    t_i,
  output sfad_pkg::cor_stat_t               stat_o,
  output logic [sfad_pkg::ZC_W-1:0]         angle_o
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ROT  = 2'd2;

  localparam logic [sfad_pkg::X_W-1:0] X_ONE =
    {{(sfad_pkg::X_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [sfad_pkg::ITER_W-1:0] I_LAST = sfad_pkg::ITER_W'(NITER - 1);

  logic [1:0]                         state_q, state_d;
  logic signed [sfad_pkg::X_W-1:0]    x_q, x_d;
  logic signed [sfad_pkg::Y_W-1:0]    y_q, y_d;
  logic signed [sfad_pkg::Z_W-1:0]    z_q, z_d;
  logic [sfad_pkg::ITER_W-1:0]        i_q, i_d;
  logic                               done_q, done_d;

  logic signed [sfad_pkg::Y_W-1:0]    dx;
  logic signed [sfad_pkg::X_W-1:0]    dy;
  logic signed [sfad_pkg::Y_W-1:0]    dy_ext;
  logic signed [sfad_pkg::Z_W-1:0]    ang;
  logic                               big;

  assign dx     = y_q >>> i_q;
  assign dy     = x_q >>> i_q;
  assign dy_ext = {{(sfad_pkg::Y_W-sfad_pkg::X_W){dy[sfad_pkg::X_W-1]}}, dy};
  assign ang    = {{(sfad_pkg::Z_W-sfad_pkg::ANG_W){1'b0}}, sfad_pkg::atan_angle(i_q)};
  // both operands are non-negative while normalizing
  assign big    = (|x_q[sfad_pkg::X_W-1:sfad_pkg::NORM_BIT]) ||
                  (|y_q[sfad_pkg::Y_W-1:sfad_pkg::NORM_BIT]);

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    done_d  = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          x_d     = X_ONE;
          y_d     = {1'b0, t_i};
          z_d     = '0;
          i_d     = '0;
          state_d = C_NORM;
        end
      end
      C_NORM: begin
        if (big) begin
          x_d = x_q >>> 1;
          y_d = y_q >>> 1;
        end else begin
          state_d = C_ROT;
        end
      end
      C_ROT: begin
        if (!y_q[sfad_pkg::Y_W-1]) begin
          x_d = x_q + dx[sfad_pkg::X_W-1:0];
          y_d = y_q - dy_ext;
          z_d = z_q + ang;
        end else begin
          x_d = x_q - dx[sfad_pkg::X_W-1:0];
          y_d = y_q + dy_ext;
          z_d = z_q - ang;
        end
        i_d = i_q + 1'b1;
        if (i_q == I_LAST) begin
          done_d  = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign stat_o.busy = (state_q != C_IDLE);
  assign stat_o.done = done_q;
  // negative final angle reads as zero
  assign angle_o = z_q[sfad_pkg::Z_W-1] ? '0 : z_q[sfad_pkg::ZC_W-1:0];

endmodule

`default_nettype wire

### rtl/core/stereo_filtered_atan_distortion.sv
// Top level: config registers, filter state, per-channel sequencer, output register.
// Depends on sfad_pkg, sfad_mul and sfad_cordic.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | in        | in_valid_i / in_stall_o   | left_in_i, right_in_i
//  out     | out       | out_valid_o / out_stall_i | left_out_o, right_out_o
//  cfg     | in        | cfg_we_i                  | cfg_addr_i, cfg_wdata_i
//
// For each channel the CORDIC first halves its operands, k = 0..17 times, until the
// pre-gained magnitude is below 2^30, then rotates; a channel whose pre-gained
// magnitude rounds to zero skips the CORDIC.
// The shared multiplier and the one-rotation-per-cycle CORDIC set the frame time.
// Reset clears filter state and loads the register defaults; no clearing pass.
// A new item is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module stereo_filtered_atan_distortion #(
  parameter int SAMPLE_BITS     = 24,
  parameter int ATAN_ITERATIONS = 20
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  wire  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       left_out_o,
  output logic signed [SAMPLE_BITS-1:0]       right_out_o,
  input  wire                                 cfg_we_i,
  input  wire  logic [sfad_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire  logic [sfad_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int FRAC    = SAMPLE_BITS - 1;
  localparam int NITER   = (ATAN_ITERATIONS < sfad_pkg::ROM_SIZE) ?
                           ATAN_ITERATIONS : sfad_pkg::ROM_SIZE;
  localparam int R_SHIFT = 46 - FRAC;
  localparam int PW      = sfad_pkg::PROD_W;
  localparam int MW      = sfad_pkg::MUL_W;

  localparam logic [PW-1:0] ONE_P   = {{(PW-1){1'b0}}, 1'b1};
  localparam logic [PW-1:0] R_HALF  = ONE_P << (45 - FRAC);
  localparam logic [PW-1:0] NEG_LIM = ONE_P << FRAC;
  localparam logic [PW-1:0] POS_LIM = NEG_LIM - ONE_P;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_M_LCG = 4'd1;
  localparam logic [3:0] S_Y1    = 4'd2;
  localparam logic [3:0] S_M_LCF = 4'd3;
  localparam logic [3:0] S_LM    = 4'd4;
  localparam logic [3:0] S_M_HCG = 4'd5;
  localparam logic [3:0] S_Y2    = 4'd6;
  localparam logic [3:0] S_M_HCF = 4'd7;
  localparam logic [3:0] S_HM    = 4'd8;
  localparam logic [3:0] S_M_DRV = 4'd9;
  localparam logic [3:0] S_T     = 4'd10;
  localparam logic [3:0] S_CWAIT = 4'd11;
  localparam logic [3:0] S_M_OS  = 4'd12;
  localparam logic [3:0] S_R     = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // config registers
  logic [sfad_pkg::GAIN_W-1:0]        lcg_q;
  logic signed [sfad_pkg::FB_W-1:0]   lcf_q;
  logic [sfad_pkg::GAIN_W-1:0]        hcg_q;
  logic signed [sfad_pkg::FB_W-1:0]   hcf_q;
  logic [sfad_pkg::DRIVE_W-1:0]       ds_q;
  logic [sfad_pkg::OSCL_W-1:0]        os_q;

  // sequencer and filter state
  logic [3:0]                         state_q, state_d;
  logic                               ch_q, ch_d;
  logic signed [sfad_pkg::MEM_W-1:0]  lm_q [2];
  logic signed [sfad_pkg::MEM_W-1:0]  hm_q [2];
  logic signed [sfad_pkg::MEM_W-1:0]  lm_d, hm_d;
  logic                               lm_we, hm_we;
  logic                               out_valid_q, out_valid_d;

  // payload registers
  logic signed [SAMPLE_BITS-1:0]      xl_q, xr_q;
  logic signed [sfad_pkg::V_W-1:0]    v_q, v_d;
  logic signed [sfad_pkg::MEM_W-1:0]  y1_q, y1_d;
  logic signed [sfad_pkg::MEM_W-1:0]  y2_q, y2_d;
  logic [SAMPLE_BITS-1:0]             resl_q, resr_q, res_d;
  logic                               res_we;
  logic [SAMPLE_BITS-1:0]             outl_q, outr_q;

  // datapath
  logic signed [MW-1:0]               mul_a, mul_b;
  logic signed [PW-1:0]               p;
  logic [PW-1:0]                      p_u;
  logic signed [sfad_pkg::ACC_W-1:0]  rp;
  logic signed [sfad_pkg::ACC_W-1:0]  v_ext;
  logic signed [sfad_pkg::ACC_W-1:0]  lm_ext, hm_ext;
  logic signed [SAMPLE_BITS-1:0]      x_cur;
  logic signed [MW-1:0]               y2_ext;
  logic [PW-1:0]                      t_sum;
  logic [sfad_pkg::T_W-1:0]           t_val;
  logic [PW-1:0]                      r_full;
  logic [SAMPLE_BITS-1:0]             res_pos, res_neg, res_r;
  logic                               in_acc;
  logic                               cor_start;
  sfad_pkg::cor_stat_t                cor_stat;
  logic [sfad_pkg::ZC_W-1:0]          angle;

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= sfad_pkg::LOW_CUT_GAIN_RST;
      lcf_q <= sfad_pkg::LOW_CUT_FEEDBACK_RST;
      hcg_q <= sfad_pkg::HIGH_CUT_GAIN_RST;
      hcf_q <= sfad_pkg::HIGH_CUT_FEEDBACK_RST;
      ds_q  <= sfad_pkg::DRIVE_SCALE_RST;
      os_q  <= sfad_pkg::OUTPUT_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sfad_pkg::REG_LOW_CUT_GAIN:      lcg_q <= cfg_wdata_i[sfad_pkg::GAIN_W-1:0];
        sfad_pkg::REG_LOW_CUT_FEEDBACK:  lcf_q <= cfg_wdata_i[sfad_pkg::FB_W-1:0];
        sfad_pkg::REG_HIGH_CUT_GAIN:     hcg_q <= cfg_wdata_i[sfad_pkg::GAIN_W-1:0];
        sfad_pkg::REG_HIGH_CUT_FEEDBACK: hcf_q <= cfg_wdata_i[sfad_pkg::FB_W-1:0];
        sfad_pkg::REG_DRIVE_SCALE:       ds_q  <= cfg_wdata_i[sfad_pkg::DRIVE_W-1:0];
        sfad_pkg::REG_OUTPUT_SCALE:      os_q  <= cfg_wdata_i[sfad_pkg::OSCL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // operand select for the shared multiplier
  assign x_cur  = ch_q ? xr_q : xl_q;
  assign y2_ext = {y2_q[sfad_pkg::MEM_W-1], y2_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M_LCG: begin
        mul_a = {{(MW-SAMPLE_BITS){x_cur[SAMPLE_BITS-1]}}, x_cur};
        mul_b = {{(MW-sfad_pkg::GAIN_W){1'b0}}, lcg_q};
      end
      S_M_LCF: begin
        mul_a = {y1_q[sfad_pkg::MEM_W-1], y1_q};
        mul_b = {{(MW-sfad_pkg::FB_W){lcf_q[sfad_pkg::FB_W-1]}}, lcf_q};
      end
      S_M_HCG: begin
        mul_a = {y1_q[sfad_pkg::MEM_W-1], y1_q};
        mul_b = {{(MW-sfad_pkg::GAIN_W){1'b0}}, hcg_q};
      end
      S_M_HCF: begin
        mul_a = y2_ext;
        mul_b = {{(MW-sfad_pkg::FB_W){hcf_q[sfad_pkg::FB_W-1]}}, hcf_q};
      end
      S_M_DRV: begin
        mul_a = y2_q[sfad_pkg::MEM_W-1] ? -y2_ext : y2_ext;
        mul_b = {{(MW-sfad_pkg::DRIVE_W){1'b0}}, ds_q};
      end
      S_M_OS: begin
        mul_a = {{(MW-sfad_pkg::ZC_W){1'b0}}, angle};
        mul_b = {{(MW-sfad_pkg::OSCL_W){1'b0}}, os_q};
      end
      default: begin
      end
    endcase
  end

  sfad_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  sfad_cordic #(
    .FRAC_BITS (FRAC),
    .NITER     (NITER)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .t_i     (t_val),
    .stat_o  (cor_stat),
    .angle_o (angle)
  );

  assign p_u    = p;
  assign rp     = sfad_pkg::rnd22(p);
  assign v_ext  = {{(sfad_pkg::ACC_W-sfad_pkg::V_W){v_q[sfad_pkg::V_W-1]}}, v_q};
  assign lm_ext = {{(sfad_pkg::ACC_W-sfad_pkg::MEM_W){lm_q[ch_q][sfad_pkg::MEM_W-1]}},
                   lm_q[ch_q]};
  assign hm_ext = {{(sfad_pkg::ACC_W-sfad_pkg::MEM_W){hm_q[ch_q][sfad_pkg::MEM_W-1]}},
                   hm_q[ch_q]};

  assign t_sum     = p_u + sfad_pkg::T_HALF;
  assign t_val     = t_sum[sfad_pkg::T_SHIFT +: sfad_pkg::T_W];
  assign cor_start = (state_q == S_T) && (t_val != '0);

  // round half up, then saturate by sign of the filter output
  assign r_full  = (p_u + R_HALF) >> R_SHIFT;
  assign res_pos = (r_full > POS_LIM) ? POS_LIM[SAMPLE_BITS-1:0] : r_full[SAMPLE_BITS-1:0];
  assign res_neg = -((r_full > NEG_LIM) ? NEG_LIM[SAMPLE_BITS-1:0]
                                        : r_full[SAMPLE_BITS-1:0]);
  assign res_r   = y2_q[sfad_pkg::MEM_W-1] ? res_neg : res_pos;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    v_d         = v_q;
    y1_d        = y1_q;
    y2_d        = y2_q;
    lm_d        = sfad_pkg::sat32(-v_ext - rp);
    hm_d        = sfad_pkg::sat32(v_ext - rp);
    lm_we       = 1'b0;
    hm_we       = 1'b0;
    res_d       = res_r;
    res_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ch_d    = 1'b0;
          state_d = S_M_LCG;
        end
      end
      S_M_LCG: state_d = S_Y1;
      S_Y1: begin
        v_d     = rp[sfad_pkg::V_W-1:0];
        y1_d    = sfad_pkg::sat32(rp + lm_ext);
        state_d = S_M_LCF;
      end
      S_M_LCF: state_d = S_LM;
      S_LM: begin
        lm_we   = 1'b1;
        state_d = S_M_HCG;
      end
      S_M_HCG: state_d = S_Y2;
      S_Y2: begin
        v_d     = rp[sfad_pkg::V_W-1:0];
        y2_d    = sfad_pkg::sat32(rp + hm_ext);
        state_d = S_M_HCF;
      end
      S_M_HCF: state_d = S_HM;
      S_HM: begin
        hm_we   = 1'b1;
        state_d = S_M_DRV;
      end
      S_M_DRV: state_d = S_T;
      S_T: begin
        if (t_val == '0) begin
          // zero argument gives exactly zero
          res_d   = '0;
          res_we  = 1'b1;
          ch_d    = 1'b1;
          state_d = ch_q ? S_DONE : S_M_LCG;
        end else begin
          state_d = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (cor_stat.done) begin
          state_d = S_M_OS;
        end
      end
      S_M_OS: state_d = S_R;
      S_R: begin
        res_we  = 1'b1;
        ch_d    = 1'b1;
        state_d = ch_q ? S_DONE : S_M_LCG;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      lm_q[0]     <= '0;
      lm_q[1]     <= '0;
      hm_q[0]     <= '0;
      hm_q[1]     <= '0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      if (lm_we) begin
        lm_q[ch_q] <= lm_d;
      end
      if (hm_we) begin
        hm_q[ch_q] <= hm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q  <= v_d;
    y1_q <= y1_d;
    y2_q <= y2_d;
    if (in_acc) begin
      xl_q <= left_in_i;
      xr_q <= right_in_i;
    end
    if (res_we) begin
      if (ch_q) begin
        resr_q <= res_d;
      end else begin
        resl_q <= res_d;
      end
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      outl_q <= resl_q;
      outr_q <= resr_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = outl_q;
  assign right_out_o = outr_q;

`ifndef ASSERT_OFF
  a_cor_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_start |-> !cor_stat.busy)
    else $error("cordic started while busy");

  a_cor_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_stat.done |-> (state_q == S_CWAIT))
    else $error("cordic result arrived outside wait state");

  a_prod_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_T || state_q == S_R) |-> !p[PW-1])
    else $error("magnitude or output product negative");

  a_done_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> ch_q)
    else $error("frame finished before right channel");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("finished frame not presented");
`endif

endmodule

`default_nettype wire

### dv/tb_stereo_filtered_atan_distortion.sv
// Self-checking testbench for stereo_filtered_atan_distortion: filters, pre-gain, CORDIC
// arctangent and output saturation checked frame by frame against an in-bench predictor.
// Depends on sfad_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_stereo_filtered_atan_distortion;

  localparam int SAMPLE_BITS      = 24;
  localparam int ATAN_ITERATIONS  = 20;
  localparam int CORDIC_STEPS     = (ATAN_ITERATIONS < 32) ? ATAN_ITERATIONS : 32;
  localparam int QUIET_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 128;
  localparam int FRAMES_PER_PHASE = 190;
  localparam int RANDOM_PHASES    = 8;

  localparam logic [sfad_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [sfad_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

  localparam int     Q22_ONE    = 4194304;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -64'sd2147483648;
  localparam longint SAMPLE_MAX = 64'sd8388607;

  typedef enum int {
    SET_TYPICAL,
    SET_HOT,
    SET_QUIET,
    SET_RAW,
    SET_EXTREME
  } setting_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } frame_t;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  in_valid_i;
  logic                                  in_stall_o;
  logic signed [SAMPLE_BITS-1:0]         left_in_i;
  logic signed [SAMPLE_BITS-1:0]         right_in_i;
  logic                                  out_valid_o;
  logic                                  out_stall_i;
  logic signed [SAMPLE_BITS-1:0]         left_out_o;
  logic signed [SAMPLE_BITS-1:0]         right_out_o;
  logic                                  cfg_we_i;
  logic [sfad_pkg::CFG_ADDR_W-1:0]       cfg_addr_i;
  logic [sfad_pkg::CFG_DATA_W-1:0]       cfg_wdata_i;

  // predictor copy of the registers and filter memories
  longint          lc_gain_q, lc_fb_q, hc_gain_q, hc_fb_q;
  longint unsigned drive_q, oscale_q;
  longint          lc_state [2];
  longint          hc_state [2];

  // atan(2^-i) in units of 2^-30 rad
  longint atan_steps [0:31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  frame_t expected_frames [$];
  frame_t head_frame;
  int     errors          = 0;
  int     frames_sent     = 0;
  int     frames_checked  = 0;
  int     settings_loaded = 0;
  int     quiet_cycles    = 0;
  bit     no_idle         = 1'b0;

  stereo_filtered_atan_distortion #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .ATAN_ITERATIONS(ATAN_ITERATIONS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .left_in_i  (left_in_i),
    .right_in_i (right_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .left_out_o (left_out_o),
    .right_out_o(right_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint round_q22(input longint p);
    return (p + 64'sd2097152) >>> 22;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] shape_sample(
    input logic signed [SAMPLE_BITS-1:0] x_in,
    input int                            ch
  );
    longint          x, v1, y1, v2, y2, sx, sy, z, dx, dy, r;
    longint unsigned mag, t, bx, by, uz;
    bit              neg;
    int              i;
    x  = x_in;
    v1 = round_q22(lc_gain_q * x);
    y1 = clamp32(v1 + lc_state[ch]);
    lc_state[ch] = clamp32(-v1 - round_q22(lc_fb_q * y1));
    v2 = round_q22(hc_gain_q * y1);
    y2 = clamp32(v2 + hc_state[ch]);
    hc_state[ch] = clamp32(v2 - round_q22(hc_fb_q * y2));

    neg = (y2 < 0);
    if (neg) mag = -y2;
    else mag = y2;
    t = (mag * drive_q + 64'd32768) >> 16;
    if (t == 0) return '0;

    // bring both CORDIC operands under 2^30 before rotating
    bx = 64'd1 << (SAMPLE_BITS - 1);
    by = t;
    while (bx >= (64'd1 << 30) || by >= (64'd1 << 30)) begin
      bx = bx >> 1;
      by = by >> 1;
    end
    sx = bx;
    sy = by;
    z  = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = sy >>> i;
      dy = sx >>> i;
      if (sy >= 0) begin
        sx = sx + dx;
        sy = sy - dy;
        z  = z + atan_steps[i];
      end else begin
        sx = sx - dx;
        sy = sy + dy;
        z  = z - atan_steps[i];
      end
    end
    if (z < 0) z = 0;

    uz = z;
    r  = (uz * oscale_q + (64'd1 << 22)) >> 23;
    if (neg) begin
      if (r > SAMPLE_MAX + 1) r = SAMPLE_MAX + 1;
      r = -r;
    end else if (r > SAMPLE_MAX) begin
      r = SAMPLE_MAX;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  task automatic reset_model();
    lc_gain_q   = 4120900;
    lc_fb_q     = -4047505;
    hc_gain_q   = 3220400;
    hc_fb_q     = 2246600;
    drive_q     = 82355;
    oscale_q    = 20840;
    lc_state[0] = 0;
    lc_state[1] = 0;
    hc_state[0] = 0;
    hc_state[1] = 0;
  endtask

  task automatic apply_reg(input logic [sfad_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [sfad_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sfad_pkg::REG_LOW_CUT_GAIN:      lc_gain_q = data[sfad_pkg::GAIN_W-1:0];
      sfad_pkg::REG_LOW_CUT_FEEDBACK:  lc_fb_q   = $signed(data[sfad_pkg::FB_W-1:0]);
      sfad_pkg::REG_HIGH_CUT_GAIN:     hc_gain_q = data[sfad_pkg::GAIN_W-1:0];
      sfad_pkg::REG_HIGH_CUT_FEEDBACK: hc_fb_q   = $signed(data[sfad_pkg::FB_W-1:0]);
      sfad_pkg::REG_DRIVE_SCALE:       drive_q   = data[sfad_pkg::DRIVE_W-1:0];
      sfad_pkg::REG_OUTPUT_SCALE:      oscale_q  = data[sfad_pkg::OSCL_W-1:0];
      default: ;  // unmapped index, nothing changes
    endcase
  endtask

  // ---------------------------------------------------------------- drivers

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 1) ? 8388607 : -8388608;
      1, 2:    v = $urandom_range(0, 511) - 256;
      default: v = $urandom;
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l_smp,
                            input logic signed [SAMPLE_BITS-1:0] r_smp);
    int     gap;
    frame_t want;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    left_in_i  = l_smp;
    right_in_i = r_smp;
    do @(posedge clk_i); while (in_stall_o);
    want.left  = shape_sample(l_smp, 0);
    want.right = shape_sample(r_smp, 1);
    expected_frames.insert(expected_frames.size(), want);
    frames_sent++;
  endtask

  // drop valid, wait for every result, then let the pipeline run dry
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [sfad_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [sfad_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic write_all(input logic [31:0] lcg, input logic [31:0] lcf,
                           input logic [31:0] hcg, input logic [31:0] hcf,
                           input logic [31:0] drv, input logic [31:0] osc);
    write_reg(sfad_pkg::REG_LOW_CUT_GAIN, lcg);
    write_reg(sfad_pkg::REG_LOW_CUT_FEEDBACK, lcf);
    write_reg(sfad_pkg::REG_HIGH_CUT_GAIN, hcg);
    write_reg(sfad_pkg::REG_HIGH_CUT_FEEDBACK, hcf);
    write_reg(sfad_pkg::REG_DRIVE_SCALE, drv);
    write_reg(sfad_pkg::REG_OUTPUT_SCALE, osc);
    settings_loaded++;
  endtask

  task automatic load_settings(input setting_kind_e kind);
    int          lcg, lcf, hcg, hcf;
    logic [31:0] drv;
    case (kind)
      SET_RAW: begin
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      SET_EXTREME: begin
        case ($urandom_range(0, 2))
          0:       lcg = 0;
          1:       lcg = Q22_ONE;
          default: lcg = 8388607;
        endcase
        case ($urandom_range(0, 3))
          0:       lcf = -Q22_ONE;
          1:       lcf = Q22_ONE;
          2:       lcf = -8388608;
          default: lcf = 8388607;
        endcase
        case ($urandom_range(0, 2))
          0:       hcg = 0;
          1:       hcg = Q22_ONE;
          default: hcg = 8388607;
        endcase
        case ($urandom_range(0, 3))
          0:       hcf = -Q22_ONE;
          1:       hcf = Q22_ONE;
          2:       hcf = -8388608;
          default: hcf = 8388607;
        endcase
        case ($urandom_range(0, 2))
          0:       drv = 32'd0;
          1:       drv = 32'd1;
          default: drv = 32'hFFFF_FFFF;
        endcase
        write_all(lcg, lcf, hcg, hcf, drv, $urandom_range(0, 1) ? 32'hFFFF : 32'h0);
      end
      default: begin
        // bilinear pairs: high-pass a = 1 - 2g, low-pass a = 2g - 1
        lcg = $urandom_range(0, Q22_ONE);
        lcf = Q22_ONE - 2 * lcg;
        hcg = $urandom_range(0, Q22_ONE);
        hcf = 2 * hcg - Q22_ONE;
        case (kind)
          SET_HOT:   drv = $urandom;
          SET_QUIET: drv = $urandom_range(0, 4);
          default:   drv = $urandom_range(1, 1 << 20);
        endcase
        write_all(lcg, lcf, hcg, hcf, drv, $urandom_range(0, 65535));
      end
    endcase
  endtask

  // receiver stall pattern
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string what,
                             input logic signed [SAMPLE_BITS-1:0] want,
                             input logic signed [SAMPLE_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got left %0d right %0d",
                 $time, left_out_o, right_out_o);
      end else begin
        head_frame = expected_frames.pop_front();
        check_field("left_out", head_frame.left, left_out_o);
        check_field("right_out", head_frame.right, right_out_o);
        frames_checked++;
      end
    end
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_frames.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_frame(24'sd0, 24'sd0);
    send_frame(24'sh7FFFFF, 24'sh7FFFFF);
    send_frame(24'sh800000, 24'sh800000);
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh800000, 24'sh7FFFFF);
    send_frame(24'sd1, -24'sd1);
    send_frame(24'sh555555, 24'shAAAAAA);
    send_frame(-24'sd1, 24'sd1);
    send_frame(24'sd0, 24'sd0);
  endtask

  task automatic test_zero_and_saturation();
    settle();
    // zero pre-gain: every output must be exactly zero
    write_reg(sfad_pkg::REG_DRIVE_SCALE, 32'd0);
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh800000, 24'sh7FFFFF);
    settle();
    // full drive and full output scale push the angle past full scale
    write_reg(sfad_pkg::REG_DRIVE_SCALE, 32'hFFFF_FFFF);
    write_reg(sfad_pkg::REG_OUTPUT_SCALE, 32'h0000_FFFF);
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh800000, 24'sh7FFFFF);
    send_frame(24'sd0, 24'sd1);
    send_frame(24'sd1, -24'sd1);
  endtask

  task automatic test_filter_overflow();
    settle();
    // gains wrap to about 2.0, feedback to -2.0 (poles at 2.0): both filter memories blow up
    write_reg(sfad_pkg::REG_LOW_CUT_GAIN, 32'hFFFF_FFFF);
    write_reg(sfad_pkg::REG_LOW_CUT_FEEDBACK, 32'h0080_0000);
    write_reg(sfad_pkg::REG_HIGH_CUT_GAIN, 32'hFFFF_FFFF);
    write_reg(sfad_pkg::REG_HIGH_CUT_FEEDBACK, 32'h0080_0000);
    write_reg(sfad_pkg::REG_OUTPUT_SCALE, 32'h0000_5168);
    repeat (3) begin
      send_frame(24'sh7FFFFF, 24'sh800000);
      send_frame(24'sh7FFFFF, 24'sh800000);
    end
  endtask

  task automatic test_unused_index();
    settle();
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_frame(24'sh123456, -24'sh123456);
    send_frame(pick_sample(), pick_sample());
  endtask

  task automatic test_random_phases();
    int            phase;
    setting_kind_e kind;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 5)
        0:       kind = SET_TYPICAL;
        1:       kind = SET_EXTREME;
        2:       kind = SET_RAW;
        3:       kind = SET_HOT;
        default: kind = SET_QUIET;
      endcase
      settle();
      load_settings(kind);
      no_idle = (kind == SET_HOT);
      repeat (FRAMES_PER_PHASE) send_frame(pick_sample(), pick_sample());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    left_in_i   = '0;
    right_in_i  = '0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    reset_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_zero_and_saturation();
    test_filter_overflow();
    test_unused_index();
    test_random_phases();
    settle();

    if (expected_frames.size() != 0) errors++;
    $display("Sent %0d frames under reset values and %0d register settings,", frames_sent,
             settings_loaded);
    $display("checked %0d results, %0d mismatches.", frames_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
